// ===== hw/rtl/pwfc_pkg.sv =====
// Package for the pulse width frame capture block.
// Holds opcode and status codes, configuration indexes and reset values.
// No dependencies.
package pwfc_pkg;

    typedef enum logic [1:0] {
        OP_EDGE        = 2'd0,
        OP_BOUNDARY    = 2'd1,
        OP_READ_PULSE  = 2'd2,
        OP_READ_SLOT   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_STORED       = 3'd0,
        ST_SHORT_DROP   = 3'd1,
        ST_FRAME_CLOSED = 3'd2,
        ST_OVERFLOW     = 3'd3,
        ST_BOUNDARY_SET = 3'd4,
        ST_READ         = 3'd5
    } t_status;

    localparam int WIDTH_W     = 16;
    localparam int FRAME_MIN_W = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int TIME_W      = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FRAME = 2'd2;

    localparam logic [WIDTH_W-1:0]     MAX_WIDTH_RST = 16'hFFFF;
    localparam logic [WIDTH_W-1:0]     MIN_WIDTH_RST = 16'h0000;
    localparam logic [FRAME_MIN_W-1:0] MIN_FRAME_RST = 10'd20;

endpackage

// ===== hw/rtl/pwfc_in_if.sv =====
// Input channel of the pulse width frame capture block.
// Depends on pwfc_pkg for field widths.
interface pwfc_in_if #(
    parameter int SW  = 9,
    parameter int SLW = 2
);
    logic                                valid;
    logic                                ready;
    logic [1:0]                          opcode;
    logic [pwfc_pkg::TIME_W-1:0]         edge_time;
    logic [SW-1:0]                       store_index;
    logic [SLW-1:0]                      slot_index;

    modport source (output valid, opcode, edge_time, store_index, slot_index, input ready);
    modport sink   (input valid, opcode, edge_time, store_index, slot_index, output ready);
endinterface

// ===== hw/rtl/pwfc_out_if.sv =====
// Result channel of the pulse width frame capture block.
// Depends on pwfc_pkg for field widths.
interface pwfc_out_if #(
    parameter int SW  = 9,
    parameter int CW  = 10,
    parameter int SLW = 2
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [pwfc_pkg::WIDTH_W-1:0] pulse_width;
    logic [SW-1:0]                written_index;
    logic [SLW-1:0]               frame_slot;
    logic [SW-1:0]                frame_start;
    logic [CW-1:0]                frame_length;
    logic [SW-1:0]                frame_last;
    logic                         frame_open;

    modport source (output valid, status, pulse_width, written_index, frame_slot,
                    frame_start, frame_length, frame_last, frame_open, input ready);
    modport sink   (input valid, status, pulse_width, written_index, frame_slot,
                    frame_start, frame_length, frame_last, frame_open, output ready);
endinterface

// ===== hw/rtl/pwfc_front.sv =====
// Front part: accepts items, measures the pulse width and classifies it.
// Depends on pwfc_pkg and pwfc_in_if.
module pwfc_front #(
    parameter int STORE_DEPTH = 512,
    parameter int FRAME_SLOTS = 4,
    parameter int SW          = $clog2(STORE_DEPTH),
    parameter int SLW         = $clog2(FRAME_SLOTS),
    parameter int EW          = 2 + pwfc_pkg::WIDTH_W + 1 + SW + SLW
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pwfc_pkg::WIDTH_W-1:0] i_max_width,
    input  logic [pwfc_pkg::WIDTH_W-1:0] i_min_width,
    pwfc_in_if.sink                      i_in,
    input  logic                         i_q_full,
    output logic                         o_push,
    output logic [EW-1:0]                o_entry
);
    logic [pwfc_pkg::WIDTH_W-1:0] r_last_time;
    logic [pwfc_pkg::WIDTH_W-1:0] n_last_time;
    logic [pwfc_pkg::WIDTH_W-1:0] width;
    logic                         in_range;
    logic [SW-1:0]                sidx;
    logic [SLW-1:0]               slot;
    logic                         is_edge;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;
    assign is_edge    = (pwfc_pkg::t_opcode'(i_in.opcode) == pwfc_pkg::OP_EDGE);

    // only the low half of the time stamps matters for a 16-bit width
    assign width    = i_in.edge_time[pwfc_pkg::WIDTH_W-1:0] - r_last_time;
    assign in_range = (width <= i_max_width) && (width >= i_min_width);

    // fold out-of-range indexes back into the store and the slot ring
    assign sidx = ({1'b0, i_in.store_index} >= (SW+1)'(STORE_DEPTH))
                ? i_in.store_index - SW'(STORE_DEPTH) : i_in.store_index;
    assign slot = ({1'b0, i_in.slot_index} >= (SLW+1)'(FRAME_SLOTS))
                ? i_in.slot_index - SLW'(FRAME_SLOTS) : i_in.slot_index;

    assign o_entry = {i_in.opcode, width, in_range, sidx, slot};

    always_comb begin
        n_last_time = r_last_time;
        if (o_push && is_edge) begin
            n_last_time = i_in.edge_time[pwfc_pkg::WIDTH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
        end else begin
            r_last_time <= n_last_time;
        end
    end
endmodule

// ===== hw/rtl/pwfc_queue.sv =====
// Two-entry queue between the front and back parts.
// No package dependencies.
module pwfc_queue #(
    parameter int EW = 38
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [EW-1:0] i_entry,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output logic [EW-1:0] o_entry
);
    logic [EW-1:0] r_buf [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          n_wr;
    logic          n_rd;
    logic [1:0]    n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_entry = r_buf[r_rd];

    always_comb begin
        n_wr  = r_wr ^ i_push;
        n_rd  = r_rd ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end
endmodule

// ===== hw/rtl/pwfc_back.sv =====
// Back part: frame bookkeeping, pulse store, slot ring and result register.
// Depends on pwfc_pkg and pwfc_out_if.
module pwfc_back #(
    parameter int STORE_DEPTH = 512,
    parameter int FRAME_SLOTS = 4,
    parameter int SW          = $clog2(STORE_DEPTH),
    parameter int CW          = $clog2(STORE_DEPTH + 1),
    parameter int SLW         = $clog2(FRAME_SLOTS),
    parameter int EW          = 2 + pwfc_pkg::WIDTH_W + 1 + SW + SLW
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [pwfc_pkg::FRAME_MIN_W-1:0] i_min_frame,
    input  logic                             i_q_valid,
    input  logic [EW-1:0]                    i_entry,
    output logic                             o_pop,
    pwfc_out_if.source                       o_out
);
    localparam logic [SW-1:0]  LAST_POS  = SW'(STORE_DEPTH - 1);
    localparam logic [SLW-1:0] LAST_SLOT = SLW'(FRAME_SLOTS - 1);
    localparam int             WW        = pwfc_pkg::WIDTH_W;

    function automatic logic [SW-1:0] pos_inc(input logic [SW-1:0] p);
        return (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SW-1:0] pos_dec(input logic [SW-1:0] p);
        return (p == '0) ? LAST_POS : p - 1'b1;
    endfunction

    // head entry fields
    pwfc_pkg::t_opcode h_op;
    logic [WW-1:0]     h_width;
    logic              h_in_range;
    logic [SW-1:0]     h_sidx;
    logic [SLW-1:0]    h_slot;

    assign h_op       = pwfc_pkg::t_opcode'(i_entry[EW-1 -: 2]);
    assign h_width    = i_entry[EW-3 -: WW];
    assign h_in_range = i_entry[SW + SLW];
    assign h_sidx     = i_entry[SLW +: SW];
    assign h_slot     = i_entry[SLW-1:0];

    // frame state; the current slot is kept in registers, closed slots in the ring
    logic [SW-1:0]  r_wp, n_wp;
    logic [SW-1:0]  r_protect, n_protect;
    logic [SLW-1:0] r_cs, n_cs;
    logic [SW-1:0]  r_cur_start, n_cur_start;
    logic [CW-1:0]  r_cur_count, n_cur_count;
    logic [SW-1:0]  r_cur_last, n_cur_last;
    // count has run past its width: the frame is long enough whatever the minimum
    logic           r_cur_wrap, n_cur_wrap;

    logic [SW-1:0]  r_ring_start [FRAME_SLOTS];
    logic [CW-1:0]  r_ring_count [FRAME_SLOTS];
    logic [SW-1:0]  r_ring_last  [FRAME_SLOTS];
    logic [FRAME_SLOTS-1:0] r_ring_vld;
    logic [SW-1:0]  r_q_start;
    logic [CW-1:0]  r_q_count;
    logic [SW-1:0]  r_q_last;
    logic           r_q_vld;

    logic [WW-1:0]  r_store [STORE_DEPTH];
    logic [WW-1:0]  r_store_q;

    // result register
    logic              r_out_valid, n_out_valid;
    pwfc_pkg::t_status r_o_status;
    logic [WW-1:0]     r_o_width;
    logic [SW-1:0]     r_o_widx;
    logic [SLW-1:0]    r_o_slot;
    logic [SW-1:0]     r_o_start;
    logic [CW-1:0]     r_o_count;
    logic [SW-1:0]     r_o_last;
    logic              r_o_pulse_sel;
    logic              r_o_ring_sel;

    pwfc_pkg::t_status st;
    logic [WW-1:0]     res_width;
    logic [SW-1:0]     res_widx;
    logic              store_we;
    logic              ring_we;
    logic              fire;
    logic              ring_sel;
    logic              kept;
    logic [SW-1:0]     wp_inc;

    assign fire  = i_q_valid && (!r_out_valid || o_out.ready);
    assign o_pop = fire;
    assign kept  = r_cur_wrap || (32'(r_cur_count) > 32'(i_min_frame));
    assign wp_inc = pos_inc(r_wp);
    assign ring_sel = (h_op == pwfc_pkg::OP_READ_SLOT) && (h_slot != r_cs);

    always_comb begin
        n_wp        = r_wp;
        n_protect   = r_protect;
        n_cs        = r_cs;
        n_cur_start = r_cur_start;
        n_cur_count = r_cur_count;
        n_cur_last  = r_cur_last;
        n_cur_wrap  = r_cur_wrap;
        st          = pwfc_pkg::ST_READ;
        res_width   = '0;
        res_widx    = '0;
        store_we    = 1'b0;
        ring_we     = 1'b0;
        case (h_op)
            pwfc_pkg::OP_EDGE: begin
                res_width = h_width;
                if (!h_in_range) begin
                    if (kept) begin
                        // close the frame into the ring and open the next slot empty
                        ring_we     = 1'b1;
                        n_protect   = r_cur_start;
                        n_cs        = (r_cs == LAST_SLOT) ? '0 : r_cs + 1'b1;
                        n_cur_start = r_wp;
                        n_cur_last  = pos_dec(r_wp);
                        n_cur_count = '0;
                        n_cur_wrap  = 1'b0;
                        st          = pwfc_pkg::ST_FRAME_CLOSED;
                    end else begin
                        // drop the short frame
                        n_wp        = r_cur_start;
                        n_cur_count = '0;
                        n_cur_wrap  = 1'b0;
                        n_cur_last  = pos_dec(r_cur_start);
                        st          = pwfc_pkg::ST_SHORT_DROP;
                    end
                end else begin
                    store_we = 1'b1;
                    res_widx = r_wp;
                    if (wp_inc == r_protect) begin
                        // ran into the consumer: rewind the frame
                        n_wp        = r_cur_start;
                        n_cur_count = '0;
                        n_cur_wrap  = 1'b0;
                        n_cur_last  = pos_dec(r_cur_start);
                        st          = pwfc_pkg::ST_OVERFLOW;
                    end else begin
                        n_wp        = wp_inc;
                        n_cur_count = r_cur_count + 1'b1;
                        n_cur_wrap  = r_cur_wrap || (r_cur_count == '1);
                        n_cur_last  = r_wp;
                        st          = pwfc_pkg::ST_STORED;
                    end
                end
            end
            pwfc_pkg::OP_BOUNDARY: begin
                n_protect = h_sidx;
                st        = pwfc_pkg::ST_BOUNDARY_SET;
            end
            pwfc_pkg::OP_READ_PULSE: begin
                st = pwfc_pkg::ST_READ;
            end
            pwfc_pkg::OP_READ_SLOT: begin
                st = pwfc_pkg::ST_READ;
            end
            default: begin
                st = pwfc_pkg::ST_READ;
            end
        endcase
        n_out_valid = fire || (r_out_valid && !o_out.ready);
    end

    // pulse store: one write or one registered read per cycle, only when an entry is taken
    always_ff @(posedge i_clk) begin
        if (fire && store_we) begin
            r_store[r_wp] <= h_width;
        end
        if (fire && (h_op == pwfc_pkg::OP_READ_PULSE)) begin
            r_store_q <= r_store[h_sidx];
        end
    end

    // slot ring: descriptors of closed frames
    always_ff @(posedge i_clk) begin
        if (fire && ring_we) begin
            r_ring_start[r_cs] <= r_cur_start;
            r_ring_count[r_cs] <= r_cur_count;
            r_ring_last[r_cs]  <= r_cur_last;
        end
        if (fire) begin
            r_q_start <= r_ring_start[h_slot];
            r_q_count <= r_ring_count[h_slot];
            r_q_last  <= r_ring_last[h_slot];
            r_q_vld   <= r_ring_vld[h_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
        end else if (fire && ring_we) begin
            r_ring_vld[r_cs] <= 1'b1;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_status    <= st;
            r_o_width     <= res_width;
            r_o_widx      <= res_widx;
            r_o_slot      <= (h_op == pwfc_pkg::OP_READ_SLOT) ? h_slot : n_cs;
            r_o_start     <= n_cur_start;
            r_o_count     <= n_cur_count;
            r_o_last      <= n_cur_last;
            r_o_pulse_sel <= (h_op == pwfc_pkg::OP_READ_PULSE);
            r_o_ring_sel  <= ring_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_protect   <= '0;
            r_cs        <= '0;
            r_cur_start <= '0;
            r_cur_count <= '0;
            r_cur_last  <= '0;
            r_cur_wrap  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (fire) begin
                r_wp        <= n_wp;
                r_protect   <= n_protect;
                r_cs        <= n_cs;
                r_cur_start <= n_cur_start;
                r_cur_count <= n_cur_count;
                r_cur_last  <= n_cur_last;
                r_cur_wrap  <= n_cur_wrap;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_o_status;
    assign o_out.pulse_width   = r_o_pulse_sel ? r_store_q : r_o_width;
    assign o_out.written_index = r_o_widx;
    assign o_out.frame_slot    = r_o_slot;
    assign o_out.frame_start   = r_o_ring_sel ? (r_q_vld ? r_q_start : '0) : r_o_start;
    assign o_out.frame_length  = r_o_ring_sel ? (r_q_vld ? r_q_count : '0) : r_o_count;
    assign o_out.frame_last    = r_o_ring_sel ? (r_q_vld ? r_q_last : '0) : r_o_last;
    assign o_out.frame_open    = !r_o_ring_sel;
endmodule

// ===== hw/rtl/pulse_width_frame_capture.sv =====
// Top level of the pulse width frame capture block.
// Depends on pwfc_pkg, pwfc_in_if, pwfc_out_if, pwfc_front, pwfc_queue, pwfc_back.
//
//  Channel   Direction  Handshake        Carries
//  i_in      in         valid/ready      opcode, edge_time, store_index, slot_index
//  o_out     out        valid/ready      status, pulse_width, written_index, frame fields
//  i_cfg_*   in         write enable     register index and data, no read-back
//
// One item per clock sustained unless o_out stalls: the front measures and
// classifies an item in the cycle it is accepted, the back retires one queue entry
// per cycle into the result register, with at most one store write or one
// registered store read per item. Items pass the queue, then the result register.
// A stalled result holds the back; the two-entry queue then fills and drops ready.
// Reset is synchronous and active low; the pulse store needs no clearing pass.
module pulse_width_frame_capture #(
    parameter int STORE_DEPTH = 512,
    parameter int FRAME_SLOTS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pwfc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [pwfc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    pwfc_in_if.sink                             i_in,
    pwfc_out_if.source                          o_out
);
    localparam int SW  = $clog2(STORE_DEPTH);
    localparam int SLW = $clog2(FRAME_SLOTS);
    localparam int CW  = $clog2(STORE_DEPTH + 1);
    localparam int EW  = 2 + pwfc_pkg::WIDTH_W + 1 + SW + SLW;

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    logic [pwfc_pkg::WIDTH_W-1:0]     r_max_width;
    logic [pwfc_pkg::WIDTH_W-1:0]     r_min_width;
    logic [pwfc_pkg::FRAME_MIN_W-1:0] r_min_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width <= pwfc_pkg::MAX_WIDTH_RST;
            r_min_width <= pwfc_pkg::MIN_WIDTH_RST;
            r_min_frame <= pwfc_pkg::MIN_FRAME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pwfc_pkg::CFG_MAX_WIDTH: begin
                    r_max_width <= i_cfg_data[pwfc_pkg::WIDTH_W-1:0];
                end
                pwfc_pkg::CFG_MIN_WIDTH: begin
                    r_min_width <= i_cfg_data[pwfc_pkg::WIDTH_W-1:0];
                end
                pwfc_pkg::CFG_MIN_FRAME: begin
                    r_min_frame <= i_cfg_data[pwfc_pkg::FRAME_MIN_W-1:0];
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // front to queue to back
    logic          push;
    logic [EW-1:0] front_entry;
    logic          q_full;
    logic          q_valid;
    logic [EW-1:0] q_entry;
    logic          pop;

    pwfc_front #(
        .STORE_DEPTH (STORE_DEPTH),
        .FRAME_SLOTS (FRAME_SLOTS),
        .SW          (SW),
        .SLW         (SLW),
        .EW          (EW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_width (r_max_width),
        .i_min_width (r_min_width),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_entry     (front_entry)
    );

    pwfc_queue #(
        .EW (EW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    pwfc_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .FRAME_SLOTS (FRAME_SLOTS),
        .SW          (SW),
        .CW          (CW),
        .SLW         (SLW),
        .EW          (EW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_min_frame (r_min_frame),
        .i_q_valid   (q_valid),
        .i_entry     (q_entry),
        .o_pop       (pop),
        .o_out       (o_out)
    );
endmodule
